// ===== rtl/core/disparity_dma_descriptor_gen_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the disparity DMA descriptor generator
// Each macro builds one labeled concurrent assertion, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef DISPARITY_DMA_DESCRIPTOR_GEN_ASSERT_SVH
`define DISPARITY_DMA_DESCRIPTOR_GEN_ASSERT_SVH

// Same-cycle implication
`define DDG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ddg assertion failed");

// Next-cycle implication
`define DDG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ddg assertion failed");

`endif

// ===== rtl/core/ddg_pkg.sv =====
// ----------------------------------------------------------------------------
// ddg_pkg
// Shared widths, codes and types of the disparity DMA descriptor generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ddg_pkg;

    localparam int IDX_W      = 24;
    localparam int DVS_W      = 32;
    localparam int ADDR_W     = 32;
    localparam int SLOT_W     = 12;
    localparam int WIN_W      = 4;
    localparam int SRCH_W     = 8;
    localparam int IMG_W      = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int BCNT_W     = 3;
    localparam int DIV_STEP   = 3;
    localparam int DIV_STAGES = IDX_W / DIV_STEP;
    localparam int PIPE_STAGES = 2 * DIV_STAGES + 3;

    localparam logic [BCNT_W-1:0] BYTE_COUNT     = 3'd4;
    localparam logic [ADDR_W-1:0] MASK_POS_BASE  = 32'd335544320;
    localparam logic [ADDR_W-1:0] MATCH_POS_BASE = 32'd352321536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_SIZE  = 3'd0,
        CFG_SEARCH_WIDTH = 3'd1,
        CFG_IMAGE_WIDTH  = 3'd2,
        CFG_RING_BASE    = 3'd3,
        CFG_LEFT_BASE    = 3'd4,
        CFG_RIGHT_BASE   = 3'd5,
        CFG_RESULT_BASE  = 3'd6,
        CFG_ENGINE_BASE  = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        KIND_LEFT,
        KIND_RIGHT,
        KIND_MASK,
        KIND_MATCH,
        KIND_RESULT
    } t_kind;

    // One stage of the restoring divider
    typedef struct packed {
        logic [DVS_W-1:0] rem;
        logic [IDX_W-1:0] quo;
        logic [IDX_W-1:0] dvd;
        logic [DVS_W-1:0] dvs;
    } t_div_st;

endpackage

`default_nettype wire

// ===== rtl/core/ddg_if.sv =====
// ----------------------------------------------------------------------------
// ddg request and result channels
// Valid/ready channels carrying the descriptor request and the descriptor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ddg_in_if import ddg_pkg::*;;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] desc_index;
    logic             wrap_last;

    modport source (output valid, output desc_index, output wrap_last, input ready);
    modport sink   (input valid, input desc_index, input wrap_last, output ready);
endinterface

interface ddg_out_if import ddg_pkg::*;;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] self_addr;
    logic [ADDR_W-1:0] next_addr;
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] dst_addr;
    logic [BCNT_W-1:0] byte_count;

    modport source (output valid, output self_addr, output next_addr, output src_addr,
                    output dst_addr, output byte_count, input ready);
    modport sink   (input valid, input self_addr, input next_addr, input src_addr,
                    input dst_addr, input byte_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ddg_div.sv =====
// ----------------------------------------------------------------------------
// ddg_div
// Pipelined restoring divider, three quotient bits per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ddg_div import ddg_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [IDX_W-1:0]  i_dividend,
    input  wire logic [DVS_W-1:0]  i_divisor,
    output logic      [IDX_W-1:0]  o_quotient,
    output logic      [DVS_W-1:0]  o_remainder
);

    t_div_st r_st [DIV_STAGES];
    t_div_st n_st [DIV_STAGES];
    t_div_st w_seed;

    // Shift in one dividend bit per step, subtract when it fits
    function automatic t_div_st div_step(input t_div_st st);
        t_div_st        res;
        logic [DVS_W:0] trial;
        res = st;
        for (int k = 0; k < DIV_STEP; k++) begin
            trial   = {res.rem, res.dvd[IDX_W-1]};
            res.dvd = {res.dvd[IDX_W-2:0], 1'b0};
            if (trial >= {1'b0, res.dvs}) begin
                trial   = trial - {1'b0, res.dvs};
                res.quo = {res.quo[IDX_W-2:0], 1'b1};
            end else begin
                res.quo = {res.quo[IDX_W-2:0], 1'b0};
            end
            res.rem = trial[DVS_W-1:0];
        end
        return res;
    endfunction

    // Compute every stage from the one before
    always_comb begin
        w_seed = '{rem: '0, quo: '0, dvd: i_dividend, dvs: i_divisor};
        n_st[0] = div_step(w_seed);
        for (int i = 1; i < DIV_STAGES; i++) begin
            n_st[i] = div_step(r_st[i-1]);
        end
    end

    // Advance all stages together
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < DIV_STAGES; i++) begin
                r_st[i] <= n_st[i];
            end
        end
    end

    assign o_quotient  = r_st[DIV_STAGES-1].quo;
    assign o_remainder = r_st[DIV_STAGES-1].rem;

endmodule

`default_nettype wire

// ===== rtl/core/disparity_dma_descriptor_gen.sv =====
// ----------------------------------------------------------------------------
// disparity_dma_descriptor_gen
// Builds one scatter-gather DMA descriptor per request for a stereo matcher.
// ----------------------------------------------------------------------------
//  channel   dir  handshake       payload
//  i_req     in   valid/ready     desc_index[23:0], wrap_last
//  o_rsp     out  valid/ready     self/next/src/dst addr[31:0], byte_count[2:0]
//  i_cfg_*   in   write enable    index[2:0], data[31:0]
//
//  One request per cycle unless stalled: two phases of 8-stage dividers in
//  series (descriptor index by group size, then pixel by row length) and three
//  address stages. The whole pipeline advances when the output register is
//  empty or taken; a stall holds every stage. Synchronous active-low reset
//  clears the valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module disparity_dma_descriptor_gen import ddg_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    ddg_in_if.sink                    i_req,
    ddg_out_if.source                 o_rsp,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [ADDR_W-1:0]    i_cfg_data
);

    // Configuration registers
    logic [WIN_W-1:0]  r_win;
    logic [SRCH_W-1:0] r_srch;
    logic [IMG_W-1:0]  r_img;
    logic [ADDR_W-1:0] r_ring, r_left, r_right, r_result, r_engine;

    logic [PIPE_STAGES-1:0] r_vld;
    logic                   w_en;

    logic [7:0]        w_mm;
    logic [SLOT_W-1:0] w_mw;
    logic [SLOT_W-1:0] w_per_pix;
    logic [ADDR_W-1:0] w_rrc;
    logic [ADDR_W-1:0] w_slack;

    // Sideband of the first and second divider phases
    logic [IDX_W-1:0]  r_sb1_idx  [DIV_STAGES];
    logic              r_sb1_wrap [DIV_STAGES];
    logic [IDX_W-1:0]  r_sb2_idx  [DIV_STAGES];
    logic              r_sb2_wrap [DIV_STAGES];
    logic [IDX_W-1:0]  r_sb2_pix  [DIV_STAGES];
    logic [SLOT_W-1:0] r_sb2_slot [DIV_STAGES];

    logic [IDX_W-1:0]  w_q_p, w_q_r, w_q_m, w_q_w;
    logic [DVS_W-1:0]  w_r_p, w_r_r, w_r_m, w_r_w;
    logic [SLOT_W-1:0] w_slot1, w_s1;
    logic [IDX_W-1:0]  w_row, w_col;
    logic [SLOT_W-1:0] w_slot2;
    t_kind             w_kind;

    // Address stages
    t_kind             r_c1_kind, r_c2_kind;
    logic [ADDR_W-1:0] r_c1_mrow, r_c1_msm, r_c1_msw, r_c1_adj;
    logic [IDX_W-1:0]  r_c1_col;
    logic [WIN_W-1:0]  r_c1_smr;
    logic [SRCH_W-1:0] r_c1_swr;
    logic [SLOT_W-1:0] r_c1_slot, r_c2_slot;
    logic [IDX_W-1:0]  r_c1_pix, r_c2_pix;
    logic [ADDR_W-1:0] r_c1_self, r_c1_next, r_c2_self, r_c2_next;
    logic [ADDR_W-1:0] r_c2_off;
    logic [ADDR_W-1:0] r_o_self, r_o_next, r_o_src, r_o_dst;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win    <= 4'd3;
            r_srch   <= 8'd18;
            r_img    <= 13'd22;
            r_ring   <= 32'h1000_0000;
            r_left   <= 32'h1100_0000;
            r_right  <= 32'h1200_0000;
            r_result <= 32'h1300_0000;
            r_engine <= 32'h7600_0000;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_WINDOW_SIZE:  r_win    <= i_cfg_data[WIN_W-1:0];
                CFG_SEARCH_WIDTH: r_srch   <= i_cfg_data[SRCH_W-1:0];
                CFG_IMAGE_WIDTH:  r_img    <= i_cfg_data[IMG_W-1:0];
                CFG_RING_BASE:    r_ring   <= i_cfg_data;
                CFG_LEFT_BASE:    r_left   <= i_cfg_data;
                CFG_RIGHT_BASE:   r_right  <= i_cfg_data;
                CFG_RESULT_BASE:  r_result <= i_cfg_data;
                CFG_ENGINE_BASE:  r_engine <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Derive group size, row length and search slack from the registers
    always_comb begin
        w_mm      = {4'd0, r_win} * {4'd0, r_win};
        w_mw      = {8'd0, r_win} * {4'd0, r_srch};
        w_per_pix = {4'd0, w_mm} + w_mw + SLOT_W'(3);
        w_rrc     = {19'd0, r_img} - ({28'd0, r_win} - 32'd1);
        w_slack   = {24'd0, r_srch} - {28'd0, r_win};
    end

    // Advance whenever the output slot frees up; take no request in reset
    assign w_en        = !r_vld[PIPE_STAGES-1] || o_rsp.ready;
    assign i_req.ready = w_en && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_STAGES-2:0], i_req.valid};
        end
    end

    // Phase one: split index into pixel and slot
    ddg_div u_div_pix (
        .i_clk       (i_clk),
        .i_en        (w_en),
        .i_dividend  (i_req.desc_index),
        .i_divisor   ({20'd0, w_per_pix}),
        .o_quotient  (w_q_p),
        .o_remainder (w_r_p)
    );

    assign w_slot1 = w_r_p[SLOT_W-1:0];
    assign w_s1    = w_slot1 - {4'd0, w_mm};

    // Phase two: pixel into row and column, slot into window coordinates
    ddg_div u_div_row (
        .i_clk       (i_clk),
        .i_en        (w_en),
        .i_dividend  (w_q_p),
        .i_divisor   (w_rrc),
        .o_quotient  (w_q_r),
        .o_remainder (w_r_r)
    );

    ddg_div u_div_win (
        .i_clk       (i_clk),
        .i_en        (w_en),
        .i_dividend  ({12'd0, w_slot1}),
        .i_divisor   ({28'd0, r_win}),
        .o_quotient  (w_q_m),
        .o_remainder (w_r_m)
    );

    ddg_div u_div_srch (
        .i_clk       (i_clk),
        .i_en        (w_en),
        .i_dividend  ({12'd0, w_s1}),
        .i_divisor   ({24'd0, r_srch}),
        .o_quotient  (w_q_w),
        .o_remainder (w_r_w)
    );

    // Carry request fields alongside the dividers
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sb1_idx[0]  <= i_req.desc_index;
            r_sb1_wrap[0] <= i_req.wrap_last;
            r_sb2_idx[0]  <= r_sb1_idx[DIV_STAGES-1];
            r_sb2_wrap[0] <= r_sb1_wrap[DIV_STAGES-1];
            r_sb2_pix[0]  <= w_q_p;
            r_sb2_slot[0] <= w_slot1;
            for (int i = 1; i < DIV_STAGES; i++) begin
                r_sb1_idx[i]  <= r_sb1_idx[i-1];
                r_sb1_wrap[i] <= r_sb1_wrap[i-1];
                r_sb2_idx[i]  <= r_sb2_idx[i-1];
                r_sb2_wrap[i] <= r_sb2_wrap[i-1];
                r_sb2_pix[i]  <= r_sb2_pix[i-1];
                r_sb2_slot[i] <= r_sb2_slot[i-1];
            end
        end
    end

    // Pick row/column (zero row length keeps the pixel as column) and kind
    always_comb begin
        w_slot2 = r_sb2_slot[DIV_STAGES-1];
        if (w_rrc == '0) begin
            w_col = r_sb2_pix[DIV_STAGES-1];
            w_row = '0;
        end else begin
            w_col = w_r_r[IDX_W-1:0];
            w_row = w_q_r;
        end
        if (w_slot2 < {4'd0, w_mm}) begin
            w_kind = KIND_LEFT;
        end else if (w_slot2 < {4'd0, w_mm} + w_mw) begin
            w_kind = KIND_RIGHT;
        end else if (w_slot2 == {4'd0, w_mm} + w_mw) begin
            w_kind = KIND_MASK;
        end else if (w_slot2 == {4'd0, w_mm} + w_mw + SLOT_W'(1)) begin
            w_kind = KIND_MATCH;
        end else begin
            w_kind = KIND_RESULT;
        end
    end

    // Stage C1: row products, column shift, descriptor links
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c1_mrow <= {8'd0, w_row} * {19'd0, r_img};
            r_c1_msm  <= {8'd0, w_q_m} * {19'd0, r_img};
            r_c1_msw  <= {8'd0, w_q_w} * {19'd0, r_img};
            r_c1_adj  <= ({8'd0, w_col} > w_slack) ? ({8'd0, w_col} - w_slack) : '0;
            r_c1_col  <= w_col;
            r_c1_smr  <= w_r_m[WIN_W-1:0];
            r_c1_swr  <= w_r_w[SRCH_W-1:0];
            r_c1_kind <= w_kind;
            r_c1_slot <= w_slot2;
            r_c1_pix  <= r_sb2_pix[DIV_STAGES-1];
            r_c1_self <= r_ring + {2'd0, r_sb2_idx[DIV_STAGES-1], 6'd0};
            r_c1_next <= r_sb2_wrap[DIV_STAGES-1] ? r_ring :
                         r_ring + {1'b0, ({1'b0, r_sb2_idx[DIV_STAGES-1]} + 25'd1), 6'd0};
        end
    end

    // Stage C2: word offset into the image
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_c1_kind == KIND_LEFT) begin
                r_c2_off <= {28'd0, r_c1_smr} + r_c1_msm + {8'd0, r_c1_col} + r_c1_mrow;
            end else begin
                r_c2_off <= {24'd0, r_c1_swr} + r_c1_msw + r_c1_mrow + r_c1_adj;
            end
            r_c2_kind <= r_c1_kind;
            r_c2_slot <= r_c1_slot;
            r_c2_pix  <= r_c1_pix;
            r_c2_self <= r_c1_self;
            r_c2_next <= r_c1_next;
        end
    end

    // Stage C3: source and destination, output register
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_self <= r_c2_self;
            r_o_next <= r_c2_next;
            case (r_c2_kind)
                KIND_LEFT: begin
                    r_o_src <= r_left + {r_c2_off[ADDR_W-3:0], 2'd0};
                    r_o_dst <= r_engine + {18'd0, r_c2_slot, 2'd0};
                end
                KIND_RIGHT: begin
                    r_o_src <= r_right + {r_c2_off[ADDR_W-3:0], 2'd0};
                    r_o_dst <= r_engine + {18'd0, r_c2_slot, 2'd0};
                end
                KIND_MASK: begin
                    r_o_src <= MASK_POS_BASE + {6'd0, r_c2_pix, 2'd0};
                    r_o_dst <= r_engine + {18'd0, r_c2_slot, 2'd0};
                end
                KIND_MATCH: begin
                    r_o_src <= MATCH_POS_BASE + {6'd0, r_c2_pix, 2'd0};
                    r_o_dst <= r_engine + {18'd0, r_c2_slot, 2'd0};
                end
                default: begin
                    r_o_src <= r_engine;
                    r_o_dst <= r_result + {6'd0, r_c2_pix, 2'd0};
                end
            endcase
        end
    end

    assign o_rsp.valid      = r_vld[PIPE_STAGES-1];
    assign o_rsp.self_addr  = r_o_self;
    assign o_rsp.next_addr  = r_o_next;
    assign o_rsp.src_addr   = r_o_src;
    assign o_rsp.dst_addr   = r_o_dst;
    assign o_rsp.byte_count = BYTE_COUNT;

`include "disparity_dma_descriptor_gen_assert.svh"

    `DDG_ASSERT_NOW(a_ready_follows_out, i_clk, i_rst_n, 1'b1, i_req.ready == (!o_rsp.valid || o_rsp.ready))
    `DDG_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_req.valid && i_req.ready, r_vld[0])
    `DDG_ASSERT_NEXT(a_stall_holds_entry, i_clk, i_rst_n, r_vld[0] && !w_en, r_vld[0])
    `DDG_ASSERT_NOW(a_self_aligned, i_clk, i_rst_n, o_rsp.valid, o_rsp.self_addr[5:0] == r_ring[5:0])

endmodule

`default_nettype wire
